### hw/rtl/weighted_union_find_defines.svh
// Assertion macros for the weighted union-find RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef WEIGHTED_UNION_FIND_DEFINES_SVH
`define WEIGHTED_UNION_FIND_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define WUF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define WUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/wuf_pkg.sv
// Package for the weighted union-find engine: sequencer states and fixed field widths.
// Depends on nothing.
package wuf_pkg;

  // Fixed widths of the beat fields.
  localparam int unsigned IN_IDX_W  = 4;
  localparam int unsigned ROOT_W    = 4;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned ACC_W     = 6;

  localparam logic [ACC_W-1:0]  ACC_MAX  = 6'd63;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_SIZE
  } wuf_state_t;

endpackage

### hw/rtl/weighted_union_find.sv
// Weighted quick-union connectivity engine: top level with its parent and size memories.
// Depends on wuf_pkg and weighted_union_find_defines.svh.
`include "weighted_union_find_defines.svh"

// Each input beat carries a pair of element indices (taken modulo NUM_ELEMENTS). The engine
// walks parent links from each element to its root, one synchronous read of the parent
// memory per cycle, then reads both tree sizes together and, if the roots differ, links the
// root of the smaller tree under the other (a tie puts the second root under the first).
// One result beat is produced per input beat. An item is accepted only in the idle state,
// so items are handled one at a time. The first read is issued at the accepting edge
// itself; the first element is then walked down to its root, then the second, and a final
// step compares sizes and writes the link. Weighted linking bounds the depth of each
// element in its tree by log2(NUM_ELEMENTS). The rate is set by the single read port of
// the parent memory, which every hop of both walks shares. After reset the engine sweeps
// the memories back to identity links and unit sizes, during which in_stall is held high.
// A finished result waits in the output register while the next item is accepted; only
// the final size-and-link cycle waits for that register to empty.
module weighted_union_find #(
  parameter int unsigned NUM_ELEMENTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wuf_pkg::IN_IDX_W-1:0]  in_first_index,
  input  logic [wuf_pkg::IN_IDX_W-1:0]  in_second_index,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_already_connected,
  output logic [wuf_pkg::ROOT_W-1:0]    out_first_root,
  output logic [wuf_pkg::ROOT_W-1:0]    out_second_root,
  output logic [wuf_pkg::ROOT_W-1:0]    out_joined_root,
  output logic [wuf_pkg::SIZE_W-1:0]    out_joined_size,
  output logic [wuf_pkg::ACC_W-1:0]     out_access_count
);

  // Index width and the width needed to hold a tree size of up to NUM_ELEMENTS.
  localparam int unsigned IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned SZ_W  = $clog2(NUM_ELEMENTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);
  localparam int unsigned IN_CODES = 1 << wuf_pkg::IN_IDX_W;

  // Parent links and tree sizes, each a synchronous memory with registered read data.
  logic [IDX_W-1:0] parent_mem [NUM_ELEMENTS];
  logic [SZ_W-1:0]  size_mem   [NUM_ELEMENTS];

  logic [IDX_W-1:0] par_raddr;
  logic [IDX_W-1:0] par_q;
  logic             par_we;
  logic [IDX_W-1:0] par_waddr;
  logic [IDX_W-1:0] par_wdata;

  logic [IDX_W-1:0] sz_raddr_a;
  logic [IDX_W-1:0] sz_raddr_b;
  logic [SZ_W-1:0]  sz_qa;
  logic [SZ_W-1:0]  sz_qb;
  logic             sz_we;
  logic [IDX_W-1:0] sz_waddr;
  logic [SZ_W-1:0]  sz_wdata;

  // Sequencer and item registers.
  wuf_pkg::wuf_state_t state_r, state_nxt;
  logic [IDX_W-1:0]          clr_r, clr_nxt;
  logic [IDX_W-1:0]          node_r, node_nxt;
  logic [IDX_W-1:0]          b_r, b_nxt;
  logic [IDX_W-1:0]          ra_r, ra_nxt;
  logic [IDX_W-1:0]          rb_r, rb_nxt;
  logic [wuf_pkg::ACC_W-1:0] acc_r, acc_nxt;

  // Result register.
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_conn_r, out_conn_nxt;
  logic [wuf_pkg::ROOT_W-1:0] out_ra_r, out_ra_nxt;
  logic [wuf_pkg::ROOT_W-1:0] out_rb_r, out_rb_nxt;
  logic [wuf_pkg::ROOT_W-1:0] out_root_r, out_root_nxt;
  logic [wuf_pkg::SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [wuf_pkg::ACC_W-1:0]  out_acc_r, out_acc_nxt;

  // Combinational helpers.
  logic [IDX_W-1:0]          idx_a;
  logic [IDX_W-1:0]          idx_b;
  logic [wuf_pkg::ACC_W-1:0] acc_inc;
  logic                      out_free;
  logic [SZ_W:0]             size_sum;
  logic [SZ_W:0]             size_val;
  logic [31:0]               size_ext;
  logic [IDX_W-1:0]          joined;
  logic [31:0]               ra_ext;
  logic [31:0]               rb_ext;
  logic [31:0]               joined_ext;

  // Incoming indices reduced modulo the element count; a 16-entry constant table.
  always_comb begin
    idx_a = '0;
    idx_b = '0;
    for (int i = 0; i < IN_CODES; i++) begin
      if (in_first_index == wuf_pkg::IN_IDX_W'(i)) begin
        idx_a = IDX_W'(i % NUM_ELEMENTS);
      end
      if (in_second_index == wuf_pkg::IN_IDX_W'(i)) begin
        idx_b = IDX_W'(i % NUM_ELEMENTS);
      end
    end
  end

  assign acc_inc  = (acc_r == wuf_pkg::ACC_MAX) ? acc_r : acc_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign size_sum = {1'b0, sz_qa} + {1'b0, sz_qb};
  assign in_stall = (state_r != wuf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wuf_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    b_r        <= b_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    acc_r      <= acc_nxt;
    out_conn_r <= out_conn_nxt;
    out_ra_r   <= out_ra_nxt;
    out_rb_r   <= out_rb_nxt;
    out_root_r <= out_root_nxt;
    out_size_r <= out_size_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  // Memories: one write port each, registered reads every cycle.
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_q <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr] <= sz_wdata;
    end
    sz_qa <= size_mem[sz_raddr_a];
    sz_qb <= size_mem[sz_raddr_b];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    acc_nxt       = acc_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_conn_nxt  = out_conn_r;
    out_ra_nxt    = out_ra_r;
    out_rb_nxt    = out_rb_r;
    out_root_nxt  = out_root_r;
    out_size_nxt  = out_size_r;
    out_acc_nxt   = out_acc_r;

    par_raddr  = node_r;
    par_we     = 1'b0;
    par_waddr  = clr_r;
    par_wdata  = clr_r;
    sz_raddr_a = ra_r;
    sz_raddr_b = rb_r;
    sz_we      = 1'b0;
    sz_waddr   = clr_r;
    sz_wdata   = SZ_W'(1);

    size_val   = {1'b0, sz_qa};
    joined     = ra_r;
    size_ext   = '0;
    ra_ext     = 32'(ra_r);
    rb_ext     = 32'(rb_r);
    joined_ext = '0;

    case (state_r)
      wuf_pkg::ST_CLEAR: begin
        // Sweep both memories back to identity links and unit sizes.
        par_we = 1'b1;
        sz_we  = 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = wuf_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      wuf_pkg::ST_IDLE: begin
        par_raddr = idx_a;
        if (in_valid) begin
          node_nxt  = idx_a;
          b_nxt     = idx_b;
          acc_nxt   = wuf_pkg::ACC_W'(1);
          state_nxt = wuf_pkg::ST_WALK_A;
        end
      end

      wuf_pkg::ST_WALK_A: begin
        acc_nxt = acc_inc;
        if (par_q == node_r) begin
          ra_nxt    = node_r;
          node_nxt  = b_r;
          par_raddr = b_r;
          state_nxt = wuf_pkg::ST_WALK_B;
        end else begin
          node_nxt  = par_q;
          par_raddr = par_q;
        end
      end

      wuf_pkg::ST_WALK_B: begin
        if (par_q == node_r) begin
          rb_nxt     = node_r;
          sz_raddr_b = node_r;
          state_nxt  = wuf_pkg::ST_SIZE;
        end else begin
          acc_nxt   = acc_inc;
          node_nxt  = par_q;
          par_raddr = par_q;
        end
      end

      wuf_pkg::ST_SIZE: begin
        if (ra_r == rb_r) begin
          size_val = {1'b0, sz_qa};
          joined   = ra_r;
        end else begin
          size_val = size_sum;
          if (sz_qa < sz_qb) begin
            joined    = rb_r;
            par_waddr = ra_r;
            par_wdata = rb_r;
          end else begin
            joined    = ra_r;
            par_waddr = rb_r;
            par_wdata = ra_r;
          end
          sz_waddr = joined;
          sz_wdata = SZ_W'(size_sum);
        end
        size_ext   = 32'(size_val);
        joined_ext = 32'(joined);
        if (out_free) begin
          par_we        = (ra_r != rb_r);
          sz_we         = (ra_r != rb_r);
          out_valid_nxt = 1'b1;
          out_conn_nxt  = (ra_r == rb_r);
          out_ra_nxt    = ra_ext[wuf_pkg::ROOT_W-1:0];
          out_rb_nxt    = rb_ext[wuf_pkg::ROOT_W-1:0];
          out_root_nxt  = joined_ext[wuf_pkg::ROOT_W-1:0];
          out_size_nxt  = (size_ext > 32'(wuf_pkg::SIZE_MAX)) ? wuf_pkg::SIZE_MAX
                                                              : size_ext[wuf_pkg::SIZE_W-1:0];
          out_acc_nxt   = (ra_r == rb_r) ? acc_r : acc_inc;
          state_nxt     = wuf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wuf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_already_connected = out_conn_r;
  assign out_first_root        = out_ra_r;
  assign out_second_root       = out_rb_r;
  assign out_joined_root       = out_root_r;
  assign out_joined_size       = out_size_r;
  assign out_access_count      = out_acc_r;

  // An accepted beat starts the first walk with one read counted.
  `WUF_ASSERT_NEXT(a_accept_starts_walk, in_valid && !in_stall, (state_r == wuf_pkg::ST_WALK_A) && (acc_r == wuf_pkg::ACC_W'(1)), "accepted beat did not start the first walk")

  // A link write never makes a root its own parent.
  `WUF_ASSERT_NOW(a_link_not_self, (state_r == wuf_pkg::ST_SIZE) && par_we, par_wdata != par_waddr, "union wrote a self link")

  // A new result only appears after the size-and-link cycle.
  `WUF_ASSERT_NOW(a_result_from_size, $rose(out_valid_r), $past(state_r) == wuf_pkg::ST_SIZE, "result raised outside the link cycle")

  // The size written on a union is never smaller than either tree it joins.
  `WUF_ASSERT_NOW(a_size_grows, (state_r == wuf_pkg::ST_SIZE) && sz_we, (sz_wdata > sz_qa) && (sz_wdata > sz_qb), "union size did not grow")

endmodule

### bench/wuf_connectivity_checker.sv
`timescale 1ns / 100ps
// Connectivity checker for the weighted union-find engine: mirrors the parent and size
// stores, predicts each result beat from the accepted pairs and compares field by field.
// Depends on wuf_pkg for the field widths and saturation limits.
module wuf_connectivity_checker #(
  parameter int unsigned NUM_ELEMENTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [wuf_pkg::IN_IDX_W-1:0]  in_first_index,
  input  logic [wuf_pkg::IN_IDX_W-1:0]  in_second_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_already_connected,
  input  logic [wuf_pkg::ROOT_W-1:0]    out_first_root,
  input  logic [wuf_pkg::ROOT_W-1:0]    out_second_root,
  input  logic [wuf_pkg::ROOT_W-1:0]    out_joined_root,
  input  logic [wuf_pkg::SIZE_W-1:0]    out_joined_size,
  input  logic [wuf_pkg::ACC_W-1:0]     out_access_count,
  output int                            error_count,
  output int                            pending_results
);

  typedef struct packed {
    logic                       connected;
    logic [wuf_pkg::ROOT_W-1:0] first_root;
    logic [wuf_pkg::ROOT_W-1:0] second_root;
    logic [wuf_pkg::ROOT_W-1:0] joined_root;
    logic [wuf_pkg::SIZE_W-1:0] joined_size;
    logic [wuf_pkg::ACC_W-1:0]  access_count;
  } union_result_t;

  // Shadow copies of the engine's parent links and tree sizes.
  logic [wuf_pkg::ROOT_W-1:0] parent_of [NUM_ELEMENTS];
  int                         set_size  [NUM_ELEMENTS];
  union_result_t              results_due [$];

  function automatic logic [wuf_pkg::ROOT_W-1:0] walk_to_root(
      input logic [wuf_pkg::IN_IDX_W-1:0] start, inout int reads);
    logic [wuf_pkg::ROOT_W-1:0] node;
    int                         hops;
    node  = wuf_pkg::ROOT_W'(int'(start) % NUM_ELEMENTS);
    hops  = 0;
    reads = reads + 1;
    while (parent_of[node] != node && hops < NUM_ELEMENTS) begin
      node  = parent_of[node];
      reads = reads + 1;
      hops  = hops + 1;
    end
    return node;
  endfunction

  // Finds both roots, links the lighter tree under the heavier one (the second root goes
  // under the first on a tie) and returns the result beat this pair should produce.
  function automatic union_result_t merge_pair(input logic [wuf_pkg::IN_IDX_W-1:0] a,
                                               input logic [wuf_pkg::IN_IDX_W-1:0] b);
    union_result_t              r;
    logic [wuf_pkg::ROOT_W-1:0] ra;
    logic [wuf_pkg::ROOT_W-1:0] rb;
    int                         reads;
    int                         total;
    reads = 0;
    ra    = walk_to_root(a, reads);
    rb    = walk_to_root(b, reads);
    if (ra == rb) begin
      r.connected   = 1'b1;
      r.joined_root = ra;
      total         = set_size[ra];
    end else begin
      r.connected = 1'b0;
      total       = set_size[ra] + set_size[rb];
      if (set_size[ra] < set_size[rb]) begin
        parent_of[ra] = rb;
        set_size[rb]  = total;
        r.joined_root = rb;
      end else begin
        parent_of[rb] = ra;
        set_size[ra]  = total;
        r.joined_root = ra;
      end
      reads = reads + 1;
    end
    if (total > int'(wuf_pkg::SIZE_MAX)) total = int'(wuf_pkg::SIZE_MAX);
    if (reads > int'(wuf_pkg::ACC_MAX)) reads = int'(wuf_pkg::ACC_MAX);
    r.first_root   = ra;
    r.second_root  = rb;
    r.joined_size  = wuf_pkg::SIZE_W'(total);
    r.access_count = wuf_pkg::ACC_W'(reads);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count = error_count + 1;
    end
  endtask

  always @(posedge clk) begin
    union_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_ELEMENTS; k++) begin
        parent_of[k] = wuf_pkg::ROOT_W'(k);
        set_size[k]  = 1;
      end
      results_due.delete();
      error_count = 0;
    end else begin
      // The result side is handled first: no beat accepted now can already have a result.
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, roots %0d/%0d", $time,
                   out_first_root, out_second_root);
          error_count = error_count + 1;
        end else begin
          want = results_due.pop_front();
          compare_field("already_connected", 8'(want.connected), 8'(out_already_connected));
          compare_field("first_root", 8'(want.first_root), 8'(out_first_root));
          compare_field("second_root", 8'(want.second_root), 8'(out_second_root));
          compare_field("joined_root", 8'(want.joined_root), 8'(out_joined_root));
          compare_field("joined_size", 8'(want.joined_size), 8'(out_joined_size));
          compare_field("access_count", 8'(want.access_count), 8'(out_access_count));
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(merge_pair(in_first_index, in_second_index));
    end
    pending_results <= results_due.size();
  end

endmodule

### bench/tb_weighted_union_find.sv
`timescale 1ns / 100ps
// Top level of the weighted union-find testbench: clock, reset, pair stimulus, result
// back-pressure and the verdict. Depends on wuf_pkg, the engine and wuf_connectivity_checker.
module tb_weighted_union_find;

  localparam int unsigned NUM_ELEMENTS = 16;
  // Long receiver hold-off used once to fill the engine and push back on the input side.
  localparam int          HOLD_CYCLES  = 300;
  // Cycles without any accepted beat before the run is abandoned. This leaves a wide margin
  // over the slowest item, heavy random stalls, the hold-off and the clearing sweep after
  // reset.
  localparam int          STUCK_LIMIT  = 5000;
  localparam int          PHASE_ITEMS  = 545;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [wuf_pkg::IN_IDX_W-1:0] in_first_index = '0;
  logic [wuf_pkg::IN_IDX_W-1:0] in_second_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_already_connected;
  logic [wuf_pkg::ROOT_W-1:0]   out_first_root;
  logic [wuf_pkg::ROOT_W-1:0]   out_second_root;
  logic [wuf_pkg::ROOT_W-1:0]   out_joined_root;
  logic [wuf_pkg::SIZE_W-1:0]   out_joined_size;
  logic [wuf_pkg::ACC_W-1:0]    out_access_count;

  int                    error_count;
  int                    pending_results;

  // Idle rates, in cycles per hundred, for the pair sender and the result receiver.
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic                  hold_req = 1'b0;
  logic                  hold_taken = 1'b0;
  int                    hold_left = 0;
  int                    stuck_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  weighted_union_find #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_index        (in_first_index),
    .in_second_index       (in_second_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_already_connected (out_already_connected),
    .out_first_root        (out_first_root),
    .out_second_root       (out_second_root),
    .out_joined_root       (out_joined_root),
    .out_joined_size       (out_joined_size),
    .out_access_count      (out_access_count)
  );

  wuf_connectivity_checker #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_index        (in_first_index),
    .in_second_index       (in_second_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_already_connected (out_already_connected),
    .out_first_root        (out_first_root),
    .out_second_root       (out_second_root),
    .out_joined_root       (out_joined_root),
    .out_joined_size       (out_joined_size),
    .out_access_count      (out_access_count),
    .error_count           (error_count),
    .pending_results       (pending_results)
  );

  // Result receiver. Normally it stalls at random at the current rate; once asked, it
  // holds off for a long stretch so that the result register stays full, the engine walks
  // its next item and then waits to write its result, pushing back on the sender.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: any accepted beat on either side shows that the engine is still moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_weighted_union_find: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offers one pair. Any idle cycles come first, with valid low; valid is then raised
  // with the new payload and held, payload unchanged, until the beat is taken. Valid is
  // only lowered when an idle cycle follows, so it never drops and rises in one step.
  task automatic send_pair(input logic [wuf_pkg::IN_IDX_W-1:0] a,
                           input logic [wuf_pkg::IN_IDX_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_index  <= a;
    in_second_index <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_pairs(input int count);
    for (int n = 0; n < count; n++)
      send_pair(wuf_pkg::IN_IDX_W'($urandom), wuf_pkg::IN_IDX_W'($urandom));
  endtask

  initial begin
    // Synchronous reset, held from time zero and never asserted again.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // First setting: the sender gaps a quarter of the time, the receiver stalls heavily.
    send_idle_pct  <= 25;
    recv_stall_pct <= 83;

    // Directed pairs. The same element twice on a fresh store, at both ends of the index
    // range, must report the pair as already connected with one read per walk.
    send_pair(4'd0, 4'd0);
    send_pair(4'd15, 4'd15);
    // Equal sizes: the second root must go under the first.
    send_pair(4'd0, 4'd1);
    send_pair(4'd2, 4'd3);
    send_pair(4'd3, 4'd1);
    send_pair(4'd4, 4'd5);
    send_pair(4'd6, 4'd7);
    send_pair(4'd4, 4'd6);
    // Two trees of four: the result is one tree of eight whose deepest leaf sits three
    // links down, so the walks that follow are long.
    send_pair(4'd7, 4'd1);
    // Already connected through deep paths: joined size is the whole tree's size.
    send_pair(4'd1, 4'd7);
    send_pair(4'd3, 4'd5);
    // A lone element as the first of the pair must go under the larger tree, and then
    // the larger tree as the first of the pair must take the lone second element.
    send_pair(4'd8, 4'd1);
    send_pair(4'd4, 4'd9);
    // Both fields at their extremes once the top end has been linked in.
    send_pair(4'd15, 4'd0);
    send_pair(4'd0, 4'd15);

    // Random pairs. The early ones do the remaining unions; after that the walks still
    // vary in depth, and every bit of both index fields is exercised.
    send_random_pairs(PHASE_ITEMS);

    // Second setting: the other way round.
    send_idle_pct  <= 83;
    recv_stall_pct <= 25;
    send_random_pairs(PHASE_ITEMS);

    // Third setting: no idling on either side, opened by one long receiver hold-off
    // while the sender keeps offering beats back to back.
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_req       <= 1'b1;
    send_random_pairs(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain: the watchdog bounds this wait should a result never come.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_weighted_union_find: clean");
    end else begin
      $display("tb_weighted_union_find: errors");
    end
    $finish;
  end

endmodule
